// ===== rtl/tkr_pkg.sv =====
// Shared types and constants for the two-key top-k ranking table.
`default_nettype none

package tkr_pkg;

  // Field widths of one record
  localparam int TAG_W     = 16;
  localparam int ATTEMPT_W = 8;
  localparam int MS_W      = 24;
  localparam int RANK_W    = 6;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 10;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [ATTEMPT_W-1:0] attempts;
    logic [MS_W-1:0]      ms;
  } rec_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic insert;  // input transaction: place the new record, reload readout chain
    logic shift;   // output transaction: readout chain moves one cell toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/top_k_two_key_ranking_top.sv =====
// Top level of the two-key top-k ranking table: cell chain, count and readout control.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   input   | in_valid/in_stall  | player_tag, attempts, elapsed_ms
//   output  | out_valid/out_stall| rank_position, out_tag, out_attempts,
//           |                    | out_elapsed_ms, was_inserted, last_of_list
//
// An input transaction places its record at once: every cell compares in parallel
// and the chain shifts behind the insert point. The readout chain is loaded at the same
// edge and then gives one record per cycle while the output side does not stall,
// count records in all (at most TABLE_DEPTH).
// in_stall stays high from an input transaction until the last record is taken.
// Reset (rst, synchronous) empties the table; record contents are left as they are.
// Output stalls hold the current record; the readout chain moves only on a transaction.
`default_nettype none

module top_k_two_key_ranking_top #(
  parameter int TABLE_DEPTH = tkr_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tkr_pkg::TAG_W-1:0]     player_tag,
  input  wire logic [tkr_pkg::ATTEMPT_W-1:0] attempts,
  input  wire logic [tkr_pkg::MS_W-1:0]      elapsed_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tkr_pkg::RANK_W-1:0]         rank_position,
  output logic [tkr_pkg::TAG_W-1:0]          out_tag,
  output logic [tkr_pkg::ATTEMPT_W-1:0]      out_attempts,
  output logic [tkr_pkg::MS_W-1:0]           out_elapsed_ms,
  output logic                               was_inserted,
  output logic                               last_of_list
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = tkr_pkg::RANK_W + 1;

  tkr_pkg::cell_ctl_t ctl;
  tkr_pkg::rec_t      fresh;
  tkr_pkg::rec_t      recs  [TABLE_DEPTH];
  tkr_pkg::rec_t      rds   [TABLE_DEPTH];
  logic               takes [TABLE_DEPTH];
  logic               valids[TABLE_DEPTH];

  logic                      busy;
  logic [CNT_W-1:0]          count;
  logic [tkr_pkg::RANK_W-1:0] pos;
  logic                      inserted;
  logic                      in_xfer;
  logic                      out_xfer;
  logic                      accept;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = busy;

  assign fresh.tag      = player_tag;
  assign fresh.attempts = attempts;
  assign fresh.ms       = elapsed_ms;

  assign ctl.insert = in_xfer;
  assign ctl.shift  = out_xfer;

  // Last cell changes only if the table has room or its record is beaten
  assign accept = takes[TABLE_DEPTH-1];

  // Cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tkr_pkg::rec_t left_rec;
    tkr_pkg::rec_t right_rd;
    logic          left_take;
    logic          left_valid;

    if (i == 0) begin : g_head
      assign left_rec   = '0;
      assign left_take  = 1'b0;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_rec   = recs[i-1];
      assign left_take  = takes[i-1];
      assign left_valid = valids[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_rd = '0;
    end else begin : g_inner
      assign right_rd = rds[i+1];
    end

    tkr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .fresh     (fresh),
      .left_take (left_take),
      .left_rec  (left_rec),
      .left_valid(left_valid),
      .right_rd  (right_rd),
      .take      (takes[i]),
      .rec       (recs[i]),
      .valid     (valids[i]),
      .rd        (rds[i])
    );
  end

  // Record count, readout position and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      pos   <= '0;
    end else if (in_xfer) begin
      busy <= 1'b1;
      pos  <= '0;
      if (accept && (count != CNT_W'(TABLE_DEPTH))) begin
        count <= count + CNT_W'(1);
      end
    end else if (out_xfer) begin
      pos <= pos + tkr_pkg::RANK_W'(1);
      if (last_of_list) begin
        busy <= 1'b0;
      end
    end
  end

  // Insert flag held for the whole readout
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      inserted <= accept;
    end
  end

  // Result payload straight from the head of the readout chain
  assign out_valid      = busy;
  assign rank_position  = pos;
  assign out_tag        = rds[0].tag;
  assign out_attempts   = rds[0].attempts;
  assign out_elapsed_ms = rds[0].ms;
  assign was_inserted   = inserted;
  assign last_of_list   = (CMP_W'(pos) + CMP_W'(1)) == CMP_W'(count);

`ifndef SYNTHESIS
  // Count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("record count above table depth");

  // Every input transaction starts a readout
  a_readout_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (out_valid && (pos == '0)))
    else $error("no readout after input transaction");

  // A readout never runs on an empty table
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("readout with empty table");

  // Taking the last record ends the readout
  a_readout_end: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_of_list) |=> !out_valid)
    else $error("readout continues past last record");
`endif

endmodule

`default_nettype wire

// ===== rtl/tkr_cell.sv =====
// One cell of the sorted record chain with its readout stage.
`default_nettype none

module tkr_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tkr_pkg::cell_ctl_t ctl,
  input  wire tkr_pkg::rec_t     fresh,
  input  wire logic              left_take,
  input  wire tkr_pkg::rec_t     left_rec,
  input  wire logic              left_valid,
  input  wire tkr_pkg::rec_t     right_rd,
  output logic                   take,
  output tkr_pkg::rec_t          rec,
  output logic                   valid,
  output tkr_pkg::rec_t          rd
);

  tkr_pkg::rec_t rec_next;
  logic          valid_next;
  logic          better;

  // New record strictly better than the held one
  assign better = (fresh.attempts < rec.attempts) ||
                  ((fresh.attempts == rec.attempts) && (fresh.ms < rec.ms));

  // Empty cell or beaten record: this cell changes on insert
  assign take = !valid || better;

  // Insert point takes the new record, cells behind it take the left neighbor
  always_comb begin
    rec_next   = rec;
    valid_next = valid;
    if (ctl.insert && take) begin
      if (left_take) begin
        rec_next   = left_rec;
        valid_next = left_valid;
      end else begin
        rec_next   = fresh;
        valid_next = 1'b1;
      end
    end
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Record and readout copy
  always_ff @(posedge clk) begin
    rec <= rec_next;
    if (ctl.insert) begin
      rd <= rec_next;
    end else if (ctl.shift) begin
      rd <= right_rd;
    end
  end

endmodule

`default_nettype wire
